// ===== hw/rtl/symbol_mismatch_distance_ratio_assert.svh =====
// Assertion macros for the symbol mismatch distance ratio block.
`ifndef SYMBOL_MISMATCH_DISTANCE_RATIO_ASSERT_SVH
`define SYMBOL_MISMATCH_DISTANCE_RATIO_ASSERT_SVH

// Same-cycle implication, checked on clk_i, off during reset.
`define SMDR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("smdr assertion failed");

// Next-cycle implication, checked on clk_i, off during reset.
`define SMDR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("smdr assertion failed");

`endif

// ===== hw/rtl/smdr_pkg.sv =====
// Package: sizes and symbol counting for the symbol mismatch distance ratio block.
`timescale 1ns / 1ps

package smdr_pkg;

  localparam int unsigned MAX_WORDS = 4096;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned RATIO_W   = 16;
  // mismatch count holds 0..MAX_WORDS, pair total holds 0..8*MAX_WORDS
  localparam int unsigned COUNT_W   = $clog2(MAX_WORDS + 1);
  localparam int unsigned TOTAL_W   = $clog2(8 * MAX_WORDS + 1);
  localparam int unsigned DIV_CNT_W = $clog2(TOTAL_W + 1);

  localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(MAX_WORDS);
  localparam logic [TOTAL_W-1:0] TOTAL_CAP = TOTAL_W'(8 * MAX_WORDS);

  // Number of nonzero 2-bit symbols in a word: OR each pair, then a sum tree.
  function automatic logic [3:0] nz_symbols(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] x;
    x = (w & 16'h5555) | ((w >> 1) & 16'h5555);
    x = (x & 16'h3333) + ((x >> 2) & 16'h3333);
    x = (x & 16'h0f0f) + ((x >> 4) & 16'h0f0f);
    x = (x & 16'h00ff) + ((x >> 8) & 16'h00ff);
    return x[3:0];
  endfunction

endpackage

// ===== hw/rtl/smdr_div.sv =====
// Restoring divider: one quotient bit per cycle through a shared subtractor.
`timescale 1ns / 1ps

module smdr_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [smdr_pkg::TOTAL_W-1:0]  dividend_i,
  input  logic [smdr_pkg::COUNT_W-1:0]  divisor_i,
  output logic                          done_o,
  output logic [smdr_pkg::TOTAL_W-1:0]  quotient_o
);

  localparam int unsigned TW = smdr_pkg::TOTAL_W;
  localparam int unsigned CW = smdr_pkg::COUNT_W;
  localparam int unsigned NW = smdr_pkg::DIV_CNT_W;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [TW-1:0] quo_q, quo_d;
  logic [CW-1:0] dsr_q, dsr_d;

  logic [CW:0]   shifted;
  logic [CW+1:0] diff;
  logic          borrow;

  assign shifted = {rem_q, quo_q[TW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_q};
  assign borrow  = diff[CW+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = NW'(TW);
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = borrow ? shifted[CW-1:0] : diff[CW-1:0];
      quo_d = {quo_q[TW-2:0], ~borrow};
      cnt_d = cnt_q - NW'(1);
      if (cnt_q == NW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== hw/rtl/symbol_mismatch_distance_ratio.sv =====
// Top level: accumulates per-pair symbol statistics and divides on the last beat.
// Input channel: word_a_i, word_b_i, last_i under in_valid_i / in_ready_o.
// Output channel: ratio_o under out_valid_o / out_ready_i, one beat per last input.
// For each input beat with last_i low, the nonzero-symbol counts and both
// saturating accumulators update at the accepting edge.
// A beat with last_i high is accumulated the same way, then the block runs a
// restoring divide, one quotient bit per cycle over TOTAL_W (16) quotient
// bits, then raises the done flag; the ratio is then registered into the
// output register once that register is free.
// in_ready_o is low from the last beat until the result is in the output
// register. The output register lets new input beats in while the result
// waits; if a second last beat finishes its divide while the first result is
// still stalled, the block holds its quotient and stays not ready until
// out_ready_i frees the register.
// Mismatch count zero gives a ratio of 0; a quotient wider than ratio_o
// saturates to all ones. Both accumulators clear on every last beat.
// Reset clears the accumulators, the sequencer and out_valid_o.
`timescale 1ns / 1ps
`include "symbol_mismatch_distance_ratio_assert.svh"

module symbol_mismatch_distance_ratio (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [smdr_pkg::WORD_W-1:0]    word_a_i,
  input  logic [smdr_pkg::WORD_W-1:0]    word_b_i,
  input  logic                           last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [smdr_pkg::RATIO_W-1:0]   ratio_o
);

  localparam int unsigned CW    = smdr_pkg::COUNT_W;
  localparam int unsigned TW    = smdr_pkg::TOTAL_W;
  localparam int unsigned RW    = smdr_pkg::RATIO_W;
  localparam int unsigned SAT_W = (TW > RW) ? TW : RW;
  localparam logic [RW-1:0] RATIO_MAX = {RW{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_HOLD = 3'b100
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [TW-1:0] total_q, total_d;
  logic          zero_q, zero_d;
  logic          out_valid_q, out_valid_d;
  logic [RW-1:0] ratio_q, ratio_d;

  logic          accept;
  logic          both_nz;
  logic          one_diff;
  logic [CW-1:0] count_acc;
  logic [TW-1:0] total_acc;
  logic          out_free;
  logic          load_out;
  logic          div_done;
  logic [TW-1:0] quotient;
  logic [SAT_W-1:0] q_ext;
  logic [RW-1:0] ratio_sat;

  assign accept   = in_valid_i && in_ready_o;
  assign both_nz  = (smdr_pkg::nz_symbols(word_a_i) != 4'd0) &&
                    (smdr_pkg::nz_symbols(word_b_i) != 4'd0);
  assign one_diff = smdr_pkg::nz_symbols(word_a_i ^ word_b_i) == 4'd1;

  // saturating accumulate of the current beat
  always_comb begin
    count_acc = count_q;
    total_acc = total_q;
    if (both_nz) begin
      if (one_diff && (count_q < smdr_pkg::COUNT_CAP)) begin
        count_acc = count_q + CW'(1);
      end
      if (total_q < smdr_pkg::TOTAL_CAP) begin
        total_acc = total_q + TW'(8);
      end
    end
  end

  smdr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && last_i),
    .dividend_i (total_acc),
    .divisor_i  (count_acc),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign q_ext     = SAT_W'(quotient);
  assign ratio_sat = zero_q ? '0 :
                     (q_ext > SAT_W'(RATIO_MAX)) ? RATIO_MAX : q_ext[RW-1:0];

  assign out_free = !out_valid_q || out_ready_i;
  assign load_out = out_free &&
                    (((state_q == ST_DIV) && div_done) || (state_q == ST_HOLD));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    total_d     = total_q;
    zero_d      = zero_q;
    out_valid_d = out_valid_q;
    ratio_d     = ratio_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
      ratio_d     = ratio_sat;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (last_i) begin
            count_d = '0;
            total_d = '0;
            zero_d  = (count_acc == '0);
            state_d = ST_DIV;
          end else begin
            count_d = count_acc;
            total_d = total_acc;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q  <= zero_d;
    ratio_q <= ratio_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign ratio_o     = ratio_q;

  `SMDR_ASSERT_NEXT(a_last_starts_div, accept && last_i, state_q == ST_DIV)
  `SMDR_ASSERT_NEXT(a_last_clears_acc, accept && last_i, count_q == '0 && total_q == '0)
  `SMDR_ASSERT_NOW(a_done_only_in_div, div_done, state_q == ST_DIV)
  `SMDR_ASSERT_NOW(a_load_needs_room, load_out, !out_valid_q || out_ready_i)

endmodule
